FILE: src/bdrr_pkg.sv
`timescale 1ns / 1ps

package bdrr_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int OUT_W     = 31;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * DATA_W;
    // Three shifted products plus a constant term, with room for carries.
    localparam int SUM_W     = PROD_W - FRAC_BITS + 3;
    // Dividend magnitude is |z| scaled up by the fraction bits.
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam logic signed [DATA_W-1:0] Q_ONE   = DATA_W'(1) <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] Q_HALF  = DATA_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_ZROW_X     = 4'd0,
        REG_ZROW_Y     = 4'd1,
        REG_ZROW_Z     = 4'd2,
        REG_ZROW_CONST = 4'd3,
        REG_WROW_X     = 4'd4,
        REG_WROW_Y     = 4'd5,
        REG_WROW_Z     = 4'd6,
        REG_WROW_CONST = 4'd7
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_SETUP,
        S_DIV,
        S_UPDATE,
        S_EMIT
    } t_state;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SUM_W'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < SUM_W'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: src/bdrr_ifs.sv
`timescale 1ns / 1ps

// Box channel: one axis-aligned box per item.
interface bdrr_box_if;
    import bdrr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] box_min_x;
    logic signed [DATA_W-1:0] box_min_y;
    logic signed [DATA_W-1:0] box_min_z;
    logic signed [DATA_W-1:0] box_max_x;
    logic signed [DATA_W-1:0] box_max_y;
    logic signed [DATA_W-1:0] box_max_z;
    logic                     last_box;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z,
        output box_max_x, box_max_y, box_max_z, last_box,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z,
        input  box_max_x, box_max_y, box_max_z, last_box,
        output ready
    );
endinterface

// Depth range channel: near and far plane distances.
interface bdrr_depth_if;
    import bdrr_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] near_depth;
    logic [OUT_W-1:0] far_depth;

    modport source (output valid, near_depth, far_depth, input ready);
    modport sink (input valid, near_depth, far_depth, output ready);
endinterface

// Configuration write channel.
interface bdrr_cfg_if;
    import bdrr_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/box_depth_range_reducer.sv
`timescale 1ns / 1ps

// Channel   | Port    | Direction | Payload
// ----------+---------+-----------+----------------------------------------------
// box       | i_box   | in        | box min/max x, y, z (Q16.16), last_box
// depth     | o_depth | out       | near_depth, far_depth (unsigned Q15.16)
// config    | i_cfg   | in        | index (4 bits), data (32 bits)
//
// A box item is worked through its 8 corners in turn. Each corner runs the products
// on the shared 32x32 multiplier, a division setup, the 1-bit-per-cycle restoring
// divider and an accumulator update. A corner whose w is zero skips the divider.
// A last box then loads the output register, waiting while the previous result
// is untaken. Reset is synchronous, active low; the box input is not ready while
// busy.
module box_depth_range_reducer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bdrr_box_if.sink            i_box,
    bdrr_depth_if.source        o_depth,
    bdrr_cfg_if.sink            i_cfg
);
    import bdrr_pkg::*;

    // Sequencer.
    t_state r_state, n_state;

    // Configuration registers.
    logic signed [DATA_W-1:0] r_zrow_x, r_zrow_y, r_zrow_z, r_zrow_const;
    logic signed [DATA_W-1:0] r_wrow_x, r_wrow_y, r_wrow_z, r_wrow_const;

    // Captured box.
    logic signed [DATA_W-1:0] r_min_x, r_min_y, r_min_z;
    logic signed [DATA_W-1:0] r_max_x, r_max_y, r_max_z;
    logic                     r_last;

    // Corner and step counters.
    logic [2:0]       r_corner, n_corner;
    logic [2:0]       r_step, n_step;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Row evaluation datapath.
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic signed [DATA_W-1:0] r_cz, n_cz;

    // Divider datapath.
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic              r_neg, n_neg;

    // Accumulators and output register.
    logic signed [DATA_W-1:0] r_near, n_near;
    logic signed [DATA_W-1:0] r_far, n_far;
    logic                     r_out_vld, n_out_vld;
    logic [OUT_W-1:0]         r_out_near, n_out_near;
    logic [OUT_W-1:0]         r_out_far, n_out_far;

    // Shared combinational terms.
    logic                     w_box_acc;
    logic                     w_out_acc;
    logic                     w_emit_load;
    logic signed [DATA_W-1:0] w_x, w_y, w_z;
    logic signed [DATA_W-1:0] w_mul_a, w_mul_b;
    logic signed [SUM_W-1:0]  w_prod_sh;
    logic signed [DATA_W-1:0] w_cw;
    logic [DATA_W-1:0]        w_cz_mag, w_cw_mag;
    logic [DATA_W:0]          w_shift;
    logic [DATA_W+1:0]        w_diff;
    logic signed [DATA_W-1:0] w_depth, w_half;

    assign w_box_acc   = i_box.valid && i_box.ready;
    assign w_out_acc   = o_depth.valid && o_depth.ready;
    assign w_emit_load = (r_state == S_EMIT) && (!r_out_vld || o_depth.ready);

    // Corner coordinates from the corner index bits.
    assign w_x = r_corner[2] ? r_max_x : r_min_x;
    assign w_y = r_corner[1] ? r_max_y : r_min_y;
    assign w_z = r_corner[0] ? r_max_z : r_min_z;

    // Multiplier operand selection per step.
    always_comb begin
        unique case (r_step)
            3'd0:    begin w_mul_a = r_zrow_x; w_mul_b = w_x; end
            3'd1:    begin w_mul_a = r_zrow_y; w_mul_b = w_y; end
            3'd2:    begin w_mul_a = r_zrow_z; w_mul_b = w_z; end
            3'd3:    begin w_mul_a = r_wrow_x; w_mul_b = w_x; end
            3'd4:    begin w_mul_a = r_wrow_y; w_mul_b = w_y; end
            3'd5:    begin w_mul_a = r_wrow_z; w_mul_b = w_z; end
            default: begin w_mul_a = '0;       w_mul_b = '0;  end
        endcase
    end

    // The arithmetic shift rounds the product toward minus infinity.
    assign w_prod_sh = SUM_W'(r_prod >>> FRAC_BITS);
    assign w_cw      = sat_s32(r_sum);
    assign w_cz_mag  = r_cz[DATA_W-1] ? (~r_cz + 1'b1) : r_cz;
    assign w_cw_mag  = w_cw[DATA_W-1] ? (~w_cw + 1'b1) : w_cw;

    // One restoring division step.
    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};

    // Signed, saturated quotient and the clamped half depth.
    always_comb begin
        if (r_neg) begin
            if (r_quo > NUM_W'(unsigned'(S32_MIN))) begin
                w_depth = S32_MIN;
            end else begin
                w_depth = ~r_quo[DATA_W-1:0] + 1'b1;
            end
        end else begin
            if (r_quo > NUM_W'(S32_MAX)) begin
                w_depth = S32_MAX;
            end else begin
                w_depth = r_quo[DATA_W-1:0];
            end
        end
        w_half = (w_depth < Q_ONE) ? Q_HALF : (w_depth >>> 1);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_box_acc) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_step == 3'd6) begin
                    n_state = S_DIV_SETUP;
                end
            end
            S_DIV_SETUP: begin
                n_state = (w_cw == '0) ? S_UPDATE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_corner != 3'd7) begin
                    n_state = S_MUL;
                end else if (r_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_corner   = r_corner;
        n_step     = r_step;
        n_cnt      = r_cnt;
        n_prod     = r_prod;
        n_sum      = r_sum;
        n_cz       = r_cz;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_dvs      = r_dvs;
        n_neg      = r_neg;
        n_near     = r_near;
        n_far      = r_far;
        n_out_vld  = r_out_vld && !w_out_acc;
        n_out_near = r_out_near;
        n_out_far  = r_out_far;

        unique case (r_state)
            S_IDLE: begin
                n_corner = '0;
                n_step   = '0;
            end
            S_MUL: begin
                // Product for this step; the previous product joins the sum.
                n_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
                n_step = r_step + 3'd1;
                unique case (r_step)
                    3'd0: n_sum = SUM_W'(r_zrow_const);
                    3'd4: begin
                        n_cz  = sat_s32(r_sum);
                        n_sum = SUM_W'(r_wrow_const) + w_prod_sh;
                    end
                    default: n_sum = r_sum + w_prod_sh;
                endcase
            end
            S_DIV_SETUP: begin
                n_rem = '0;
                n_dvs = w_cw_mag;
                n_cnt = CNT_W'(NUM_W - 1);
                if (w_cw == '0) begin
                    // Zero w saturates the depth to the largest value.
                    n_quo = NUM_W'(S32_MAX);
                    n_neg = 1'b0;
                end else begin
                    n_quo = {w_cz_mag, {FRAC_BITS{1'b0}}};
                    n_neg = (r_cz > 0) ^ w_cw[DATA_W-1];
                end
            end
            S_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (!w_diff[DATA_W+1]) begin
                    n_rem = w_diff[DATA_W-1:0];
                    n_quo = {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = w_shift[DATA_W-1:0];
                    n_quo = {r_quo[NUM_W-2:0], 1'b0};
                end
            end
            S_UPDATE: begin
                if (w_depth > r_far) begin
                    n_far = w_depth;
                end
                if (w_half < r_near) begin
                    n_near = w_half;
                end
                n_corner = r_corner + 3'd1;
                n_step   = '0;
            end
            S_EMIT: begin
                if (w_emit_load) begin
                    n_out_vld  = 1'b1;
                    n_out_near = r_near[OUT_W-1:0];
                    n_out_far  = r_far[OUT_W-1:0];
                    n_near     = S32_MAX;
                    n_far      = Q_HALF;
                end
            end
            default: ;
        endcase
    end

    // Handshake and payload outputs.
    always_comb begin
        i_box.ready        = (r_state == S_IDLE);
        i_cfg.ready        = 1'b1;
        o_depth.valid      = r_out_vld;
        o_depth.near_depth = r_out_near;
        o_depth.far_depth  = r_out_far;
    end

    // Control state, accumulators and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_near       <= S32_MAX;
            r_far        <= Q_HALF;
            r_zrow_x     <= '0;
            r_zrow_y     <= '0;
            r_zrow_z     <= Q_ONE;
            r_zrow_const <= '0;
            r_wrow_x     <= '0;
            r_wrow_y     <= '0;
            r_wrow_z     <= '0;
            r_wrow_const <= Q_ONE;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_near    <= n_near;
            r_far     <= n_far;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_ZROW_X:     r_zrow_x     <= i_cfg.data;
                    REG_ZROW_Y:     r_zrow_y     <= i_cfg.data;
                    REG_ZROW_Z:     r_zrow_z     <= i_cfg.data;
                    REG_ZROW_CONST: r_zrow_const <= i_cfg.data;
                    REG_WROW_X:     r_wrow_x     <= i_cfg.data;
                    REG_WROW_Y:     r_wrow_y     <= i_cfg.data;
                    REG_WROW_Z:     r_wrow_z     <= i_cfg.data;
                    REG_WROW_CONST: r_wrow_const <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (w_box_acc) begin
            r_min_x <= i_box.box_min_x;
            r_min_y <= i_box.box_min_y;
            r_min_z <= i_box.box_min_z;
            r_max_x <= i_box.box_max_x;
            r_max_y <= i_box.box_max_y;
            r_max_z <= i_box.box_max_z;
            r_last  <= i_box.last_box;
        end
        r_corner   <= n_corner;
        r_step     <= n_step;
        r_cnt      <= n_cnt;
        r_prod     <= n_prod;
        r_sum      <= n_sum;
        r_cz       <= n_cz;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_neg      <= n_neg;
        r_out_near <= n_out_near;
        r_out_far  <= n_out_far;
    end

endmodule

FILE: tb/box_depth_range_reducer_tb.sv
`timescale 1ns / 1ps

module box_depth_range_reducer_tb;
    import bdrr_pkg::*;

    // Run control.
    localparam longint CYCLE_LIMIT      = 3_000_000;
    localparam int     BOX_CYCLES       = 8 * 57 + 2;
    localparam int     DRAIN_CYCLES     = BOX_CYCLES + 32;
    localparam int     HOLD_CYCLES      = 6000;
    localparam int     NUM_PHASES       = 12;
    localparam int     ITEMS_PER_PHASE  = 86;
    localparam int     PRESSURE_PHASE   = 4;
    localparam int     MAX_REPORTED     = 200;
    localparam int     NUM_MATRIX_REGS  = 8;

    // Indexes past the last matrix register; writes to them must be ignored.
    localparam logic [IDX_W-1:0] IDX_UNUSED_FIRST = IDX_W'(REG_WROW_CONST) + 1'b1;
    localparam logic [IDX_W-1:0] IDX_UNUSED_LAST  = '1;

    // Fixed-point helpers for stimulus and prediction.
    localparam int     Q1           = int'(Q_ONE);
    localparam int     SCENE_SPAN   = 200 * Q1;
    localparam int     EXTENT_SPAN  = 20 * Q1;
    localparam int     COEF_JITTER  = Q1 / 20;
    localparam longint DEPTH_MAX    = longint'(S32_MAX);
    localparam longint DEPTH_MIN    = longint'(S32_MIN);
    localparam longint DEPTH_ONE    = longint'(Q_ONE);
    localparam longint DEPTH_HALF   = longint'(Q_HALF);

    typedef enum int {
        CFG_IDENTITY,
        CFG_ZERO_W,
        CFG_W_FROM_Z,
        CFG_PERSPECTIVE,
        CFG_RANDOM,
        CFG_ALL_MAX,
        CFG_ALL_MIN
    } cfg_style_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_x;
        logic signed [DATA_W-1:0] min_y;
        logic signed [DATA_W-1:0] min_z;
        logic signed [DATA_W-1:0] max_x;
        logic signed [DATA_W-1:0] max_y;
        logic signed [DATA_W-1:0] max_z;
        logic                     last;
    } box_t;

    typedef struct packed {
        logic [OUT_W-1:0] near_depth;
        logic [OUT_W-1:0] far_depth;
    } depth_range_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdrr_box_if   box_if ();
    bdrr_depth_if depth_if ();
    bdrr_cfg_if   cfg_if ();

    box_depth_range_reducer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_if),
        .o_depth (depth_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: a copy of the matrix rows and the running depth range.
    logic signed [DATA_W-1:0] matrix_rows [NUM_MATRIX_REGS];
    longint                   near_run;
    longint                   far_run;
    depth_range_t             pending_ranges [$];

    // Traffic bookkeeping shared by the driver, monitor and sequence.
    box_t       box_queue [$];
    longint     boxes_queued   = 0;
    longint     boxes_taken    = 0;
    bit         box_taken_flag = 1'b0;
    bit         box_offered    = 1'b0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_request   = 1'b0;
    int         hold_left      = 0;
    longint     cycle_count    = 0;
    int         fail_count     = 0;

    cfg_style_t phase_style [NUM_PHASES] = '{
        CFG_PERSPECTIVE, CFG_RANDOM, CFG_PERSPECTIVE, CFG_ALL_MAX,
        CFG_PERSPECTIVE, CFG_W_FROM_Z, CFG_RANDOM, CFG_PERSPECTIVE,
        CFG_ALL_MIN, CFG_PERSPECTIVE, CFG_IDENTITY, CFG_PERSPECTIVE
    };

    // Clock with a 2 ns period.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTED) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic longint clamp_word(input longint v);
        if (v > DEPTH_MAX) begin
            return DEPTH_MAX;
        end
        if (v < DEPTH_MIN) begin
            return DEPTH_MIN;
        end
        return v;
    endfunction

    // One matrix row applied to a corner: products floored to the fixed-point
    // grid, summed exactly with the translation term, then clamped.
    function automatic longint project_row(input int base, input longint px,
                                           input longint py, input longint pz);
        longint acc;
        acc = ((longint'(matrix_rows[base]) * px) >>> FRAC_BITS)
            + ((longint'(matrix_rows[base + 1]) * py) >>> FRAC_BITS)
            + ((longint'(matrix_rows[base + 2]) * pz) >>> FRAC_BITS)
            + longint'(matrix_rows[base + 3]);
        return clamp_word(acc);
    endfunction

    // Depth of a corner is -z/w, truncated; a zero w saturates to the maximum.
    function automatic longint corner_depth(input longint px, input longint py,
                                            input longint pz);
        longint cz;
        longint cw;
        cz = project_row(int'(REG_ZROW_X), px, py, pz);
        cw = project_row(int'(REG_WROW_X), px, py, pz);
        if (cw == 0) begin
            return DEPTH_MAX;
        end
        return clamp_word((-cz <<< FRAC_BITS) / cw);
    endfunction

    // Fold the eight corners of a box into the running range; a box that
    // closes a set yields the expected near and far distances.
    function automatic void fold_box_depths(input box_t b);
        longint       lo [3];
        longint       hi [3];
        longint       d;
        longint       half_d;
        int           c;
        depth_range_t r;
        lo[0] = longint'(signed'(b.min_x));
        lo[1] = longint'(signed'(b.min_y));
        lo[2] = longint'(signed'(b.min_z));
        hi[0] = longint'(signed'(b.max_x));
        hi[1] = longint'(signed'(b.max_y));
        hi[2] = longint'(signed'(b.max_z));
        for (c = 0; c < 8; c++) begin
            d = corner_depth(c[2] ? hi[0] : lo[0], c[1] ? hi[1] : lo[1],
                             c[0] ? hi[2] : lo[2]);
            if (d > far_run) begin
                far_run = d;
            end
            half_d = (d < DEPTH_ONE) ? DEPTH_HALF : (d >>> 1);
            if (half_d < near_run) begin
                near_run = half_d;
            end
        end
        if (b.last) begin
            r.near_depth = near_run[OUT_W-1:0];
            r.far_depth  = far_run[OUT_W-1:0];
            pending_ranges = {pending_ranges, r};
            near_run = DEPTH_MAX;
            far_run  = DEPTH_HALF;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] extreme_word();
        case ($urandom_range(4))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return '0;
            3: return '1;
            default: return Q_ONE;
        endcase
    endfunction

    function automatic int coef_jitter();
        return int'($urandom_range(2 * COEF_JITTER)) - COEF_JITTER;
    endfunction

    // Mostly well-formed boxes in front of the camera, with a share of raw
    // words, inverted boxes, points and extreme values.
    function automatic box_t make_box(input logic is_last);
        box_t        b;
        int unsigned pick;
        int          cx;
        int          cy;
        int          cz;
        int          ex;
        int          ey;
        int          ez;
        pick = $urandom_range(99);
        cx = int'($urandom_range(2 * SCENE_SPAN)) - SCENE_SPAN;
        cy = int'($urandom_range(2 * SCENE_SPAN)) - SCENE_SPAN;
        cz = 8 * Q1 - int'($urandom_range(SCENE_SPAN));
        ex = int'($urandom_range(EXTENT_SPAN));
        ey = int'($urandom_range(EXTENT_SPAN));
        ez = int'($urandom_range(EXTENT_SPAN));
        if (pick >= 90 && pick < 95) begin
            ex = 0;
            ey = 0;
            ez = 0;
            if ($urandom_range(1) == 0) begin
                cx = 0;
                cy = 0;
                cz = 0;
            end
        end
        b.min_x = cx - ex;
        b.min_y = cy - ey;
        b.min_z = cz - ez;
        b.max_x = cx + ex;
        b.max_y = cy + ey;
        b.max_z = cz + ez;
        if (pick >= 65 && pick < 80) begin
            b.min_x = $urandom();
            b.min_y = $urandom();
            b.min_z = $urandom();
            b.max_x = $urandom();
            b.max_y = $urandom();
            b.max_z = $urandom();
        end else if (pick >= 80 && pick < 90) begin
            // Inverted on a random subset of axes.
            if ($urandom_range(1) == 1) begin
                b.min_x = cx + ex + 1;
                b.max_x = cx - ex;
            end
            if ($urandom_range(1) == 1) begin
                b.min_y = cy + ey + 1;
                b.max_y = cy - ey;
            end
            if ($urandom_range(1) == 1) begin
                b.min_z = cz + ez + 1;
                b.max_z = cz - ez;
            end
        end else if (pick >= 95) begin
            b.min_x = extreme_word();
            b.min_y = extreme_word();
            b.min_z = extreme_word();
            b.max_x = extreme_word();
            b.max_y = extreme_word();
            b.max_z = extreme_word();
        end
        b.last = is_last;
        return b;
    endfunction

    task automatic queue_box(input box_t b);
        box_queue = {box_queue, b};
        boxes_queued++;
    endtask

    task automatic queue_corners(input logic signed [DATA_W-1:0] lx, ly, lz,
                                 input logic signed [DATA_W-1:0] hx, hy, hz,
                                 input logic is_last);
        box_t b;
        b.min_x = lx;
        b.min_y = ly;
        b.min_z = lz;
        b.max_x = hx;
        b.max_y = hy;
        b.max_z = hz;
        b.last  = is_last;
        queue_box(b);
    endtask

    // One register write; the predictor copy changes when the block takes it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        if (idx <= REG_WROW_CONST) begin
            matrix_rows[idx] = val;
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_config(input cfg_style_t style);
        logic [DATA_W-1:0] vals [NUM_MATRIX_REGS];
        int                i;
        for (i = 0; i < NUM_MATRIX_REGS; i++) begin
            vals[i] = '0;
        end
        case (style)
            CFG_IDENTITY: begin
                vals[REG_ZROW_Z]     = Q_ONE;
                vals[REG_WROW_CONST] = Q_ONE;
            end
            CFG_ZERO_W: begin
                vals[REG_ZROW_Z] = Q_ONE;
            end
            CFG_W_FROM_Z: begin
                // w equals z, so corners on the z = 0 plane divide by zero.
                vals[REG_ZROW_Z]     = Q_ONE;
                vals[REG_ZROW_CONST] = Q_ONE;
                vals[REG_WROW_Z]     = Q_ONE;
            end
            CFG_PERSPECTIVE: begin
                vals[REG_ZROW_X]     = coef_jitter();
                vals[REG_ZROW_Y]     = coef_jitter();
                vals[REG_ZROW_Z]     = -(Q1 + int'($urandom_range(Q1 / 2)));
                vals[REG_ZROW_CONST] = -int'($urandom_range(2 * Q1));
                vals[REG_WROW_X]     = coef_jitter();
                vals[REG_WROW_Y]     = coef_jitter();
                vals[REG_WROW_Z]     = -Q1 + coef_jitter();
                vals[REG_WROW_CONST] = coef_jitter();
            end
            CFG_RANDOM: begin
                for (i = 0; i < NUM_MATRIX_REGS; i++) begin
                    vals[i] = $urandom();
                end
            end
            CFG_ALL_MAX: begin
                for (i = 0; i < NUM_MATRIX_REGS; i++) begin
                    vals[i] = S32_MAX;
                end
            end
            default: begin
                for (i = 0; i < NUM_MATRIX_REGS; i++) begin
                    vals[i] = S32_MIN;
                end
            end
        endcase
        for (i = 0; i < NUM_MATRIX_REGS; i++) begin
            write_reg(IDX_W'(i), vals[i]);
        end
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 70;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 70;
            end
            default: begin
                send_idle_pct  = 35;
                recv_stall_pct = 35;
            end
        endcase
    endtask

    // Wait until every box is taken and every range has come out, then give
    // the block time to finish a box that closes no set.
    task automatic wait_until_drained();
        while (boxes_taken != boxes_queued || pending_ranges.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Box driver: offers queued items at the falling edge, holding each one
    // until it is taken.
    always @(negedge i_clk) begin : box_driver
        box_t next_box;
        if (box_taken_flag) begin
            box_taken_flag = 1'b0;
            box_offered    = 1'b0;
        end
        if (!box_offered) begin
            if (box_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_box = box_queue.pop_front();
                box_if.valid     <= 1'b1;
                box_if.box_min_x <= next_box.min_x;
                box_if.box_min_y <= next_box.min_y;
                box_if.box_min_z <= next_box.min_z;
                box_if.box_max_x <= next_box.max_x;
                box_if.box_max_y <= next_box.max_y;
                box_if.box_max_z <= next_box.max_z;
                box_if.last_box  <= next_box.last;
                box_offered = 1'b1;
            end else begin
                box_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted on its own.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready with random stalls.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            depth_if.ready <= 1'b0;
        end else begin
            depth_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every taken box and checks every taken range.
    always @(posedge i_clk) begin : monitor
        box_t         seen_box;
        depth_range_t want;
        cycle_count++;
        if (i_rst_n && box_if.valid && box_if.ready) begin
            seen_box.min_x = box_if.box_min_x;
            seen_box.min_y = box_if.box_min_y;
            seen_box.min_z = box_if.box_min_z;
            seen_box.max_x = box_if.box_max_x;
            seen_box.max_y = box_if.box_max_y;
            seen_box.max_z = box_if.box_max_z;
            seen_box.last  = box_if.last_box;
            fold_box_depths(seen_box);
            boxes_taken++;
            box_taken_flag = 1'b1;
        end
        if (i_rst_n && depth_if.valid && depth_if.ready) begin
            if (pending_ranges.size() == 0) begin
                report_mismatch($sformatf("unexpected range near %h far %h",
                                          depth_if.near_depth, depth_if.far_depth));
            end else begin
                want = pending_ranges.pop_front();
                if (depth_if.near_depth !== want.near_depth) begin
                    report_mismatch($sformatf("near_depth got %h expected %h",
                                              depth_if.near_depth, want.near_depth));
                end
                if (depth_if.far_depth !== want.far_depth) begin
                    report_mismatch($sformatf("far_depth got %h expected %h",
                                              depth_if.far_depth, want.far_depth));
                end
            end
        end
    end

    // Watchdog.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Sequence: reset, directed boxes, then randomized phases.
    initial begin : sequence_main
        int phase;
        int count;
        int set_len;
        int k;
        box_t b;

        i_rst_n          = 1'b0;
        box_if.valid     = 1'b0;
        box_if.box_min_x = '0;
        box_if.box_min_y = '0;
        box_if.box_min_z = '0;
        box_if.box_max_x = '0;
        box_if.box_max_y = '0;
        box_if.box_max_z = '0;
        box_if.last_box  = 1'b0;
        depth_if.ready   = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;

        // Predictor starts from the reset state.
        for (k = 0; k < NUM_MATRIX_REGS; k++) begin
            matrix_rows[k] = '0;
        end
        matrix_rows[REG_ZROW_Z]     = Q_ONE;
        matrix_rows[REG_WROW_CONST] = Q_ONE;
        near_run = DEPTH_MAX;
        far_run  = DEPTH_HALF;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset matrix: depth is simply -z.
        // A set made of a single box, then an all-zero box.
        queue_corners(0, 0, -2 * Q1, 0, 0, -Q1, 1'b1);
        queue_corners(0, 0, 0, 0, 0, 0, 1'b1);
        // Full-range box joined with a box whose depth stays below one.
        queue_corners(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 1'b0);
        queue_corners(0, 0, -Q1 / 2, 0, 0, -Q1 / 4, 1'b1);
        // Inverted box joined with a box behind the camera.
        queue_corners(5 * Q1, 5 * Q1, -Q1, -5 * Q1, -5 * Q1, -30 * Q1, 1'b0);
        queue_corners(-Q1, -Q1, 10 * Q1, Q1, Q1, 50 * Q1, 1'b1);
        // Smallest steps and alternating bit patterns.
        queue_corners(-1, -1, -1, 1, 1, 1, 1'b1);
        queue_corners(32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA,
                      32'h55555555, 32'h55555555, 32'h55555555, 1'b1);
        queue_corners(32'h55555555, 32'h55555555, 32'h55555555,
                      32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 1'b1);
        wait_until_drained();

        // w is zero everywhere, so every depth saturates. Writes past the
        // last register must leave the matrix alone.
        load_config(CFG_ZERO_W);
        write_reg(IDX_UNUSED_FIRST, $urandom());
        write_reg(IDX_UNUSED_LAST, $urandom());
        queue_box(make_box(1'b0));
        queue_box(make_box(1'b1));
        wait_until_drained();

        // Largest coefficients: row sums saturate.
        load_config(CFG_ALL_MAX);
        queue_corners(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 1'b1);
        queue_corners($urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), 1'b1);
        wait_until_drained();

        load_config(CFG_ALL_MIN);
        queue_corners(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, 1'b0);
        queue_corners(0, 0, 0, 0, 0, 0, 1'b1);
        wait_until_drained();

        // w follows z: a corner on z = 0 divides by zero, z = -1 gives depth 0.
        load_config(CFG_W_FROM_Z);
        queue_corners(-Q1, -Q1, -Q1, Q1, Q1, 0, 1'b1);
        queue_corners(-Q1, -Q1, -3 * Q1, Q1, Q1, -2 * Q1, 1'b1);

        // Randomized phases, each with its own matrix and idling pattern.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_until_drained();
            load_config(phase_style[phase]);
            set_idling(idle_mode_t'(phase % 4));
            if (phase == PRESSURE_PHASE) begin
                hold_request = 1'b1;
            end
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                set_len = (phase == PRESSURE_PHASE) ? $urandom_range(1, 2)
                                                    : $urandom_range(1, 6);
                for (k = 1; k <= set_len; k++) begin
                    b = make_box(k == set_len);
                    queue_box(b);
                    count++;
                end
            end
        end
        wait_until_drained();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: box_depth_range_reducer.f
src/bdrr_pkg.sv
src/bdrr_ifs.sv
src/box_depth_range_reducer.sv
tb/box_depth_range_reducer_tb.sv
